### src/alrd_pkg.sv
// shared constants, codes and the window compare for the ladder rotary decoder
`default_nettype none

package alrd_pkg;

   localparam int CHANNELS    = 3;
   localparam int SAMPLE_BITS = 12;
   localparam int CHAN_BITS   = 2;
   localparam int TOL_BITS    = 10;
   localparam int EVENT_BITS  = 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = SAMPLE_BITS;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_BITS = ((CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_USED_BITS = EVENT_BITS + CHAN_BITS;
   localparam int RSP_DATA_BITS = ((RSP_USED_BITS + 7) / 8) * 8;

   // reset values of the register file
   localparam logic [SAMPLE_BITS-1:0] LEVEL_A_RESET    = SAMPLE_BITS'(1024);
   localparam logic [SAMPLE_BITS-1:0] LEVEL_B_RESET    = SAMPLE_BITS'(2048);
   localparam logic [SAMPLE_BITS-1:0] LEVEL_C_RESET    = SAMPLE_BITS'(3072);
   localparam logic [SAMPLE_BITS-1:0] LEVEL_D_RESET    = SAMPLE_BITS'(3900);
   localparam logic [TOL_BITS-1:0]    TOLERANCE_RESET  = TOL_BITS'(100);
   localparam logic [SAMPLE_BITS-1:0] PRESS_LOW_RESET  = SAMPLE_BITS'(8'h0A);
   localparam logic [SAMPLE_BITS-1:0] PRESS_HIGH_RESET = SAMPLE_BITS'(8'h20);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_LEVEL_A    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_LEVEL_B    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_LEVEL_C    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_LEVEL_D    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_TOLERANCE  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_PRESS_LOW  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_PRESS_HIGH = 3'd6;

   typedef enum logic [EVENT_BITS-1:0] {
      EV_NONE  = 2'd0,
      EV_RIGHT = 2'd1,
      EV_LEFT  = 2'd2,
      EV_PRESS = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      SITE_EMPTY = 2'd0,
      SITE_A     = 2'd1,
      SITE_C     = 2'd2
   } site_type;

   // inclusive window level +/- tol, lower edge clamped at zero, upper edge without wrap
   function automatic logic in_window(
      input logic [SAMPLE_BITS-1:0] s,
      input logic [SAMPLE_BITS-1:0] level,
      input logic [TOL_BITS-1:0]    tol
   );
      logic [SAMPLE_BITS:0] tol_x;
      logic [SAMPLE_BITS:0] lvl_x;
      logic [SAMPLE_BITS:0] lo;
      logic [SAMPLE_BITS:0] hi;
      tol_x = (SAMPLE_BITS + 1)'(tol);
      lvl_x = {1'b0, level};
      hi    = lvl_x + tol_x;
      lo    = (lvl_x >= tol_x) ? (lvl_x - tol_x) : '0;
      return ({1'b0, s} >= lo) && ({1'b0, s} <= hi);
   endfunction

endpackage

`default_nettype wire

### src/adc_ladder_rotary_decoder_core.sv
// rotary encoder decoder for encoders read through a resistor ladder
`default_nettype none

// channel  direction  payload
// req_     in         tdata: channel [1:0], sample [13:2], zero pad [15:14]
// rsp_     out        tdata: event_code [1:0], event_channel [3:2], zero pad [7:4]
// csr_     in         csr_index selects register, csr_data is the value, always ready
//
// one item per cycle while results are taken; an item moves from the input register
// into the result register and sits there until taken, the window compares and the
// site update lie between the two
// a stalled result freezes the input register, and a new item still enters while
// the input register is empty or moving on
// reset clears all channel sites and valids and sets the register file to its defaults

module adc_ladder_rotary_decoder_core (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // channel [1:0], sample [13:2], zero pad above
   input  wire logic [alrd_pkg::REQ_DATA_BITS-1:0]  req_tdata,

   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // event_code [1:0], event_channel [3:2], zero pad above
   output logic [alrd_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [alrd_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [alrd_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import alrd_pkg::*;

   // register file
   logic [SAMPLE_BITS-1:0] level_a_ff, level_b_ff, level_c_ff, level_d_ff;
   logic [TOL_BITS-1:0]    tolerance_ff;
   logic [SAMPLE_BITS-1:0] press_low_ff, press_high_ff;

   // input register
   logic                   in_valid_ff;
   logic [CHAN_BITS-1:0]   in_channel_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;

   // result register
   logic                   rsp_valid_ff;
   event_type              rsp_event_ff;
   logic [CHAN_BITS-1:0]   rsp_channel_ff;

   // per channel first site
   site_type               site_ff [CHANNELS];

   logic      advance;
   logic      in_range;
   site_type  site_cur;
   site_type  site_in;
   logic      site_write;
   event_type event_in;
   logic      hit_a, hit_b, hit_c, hit_d, hit_press;

   assign csr_ready  = 1'b1;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - RSP_USED_BITS)'(0), rsp_channel_ff, rsp_event_ff};

   assign in_range = int'(in_channel_ff) < CHANNELS;

   // site of the channel held in the input register
   always_comb begin
      site_cur = SITE_EMPTY;
      for (int i = 0; i < CHANNELS; i++) begin
         if (int'(in_channel_ff) == i) begin
            site_cur = site_ff[i];
         end
      end
   end

   assign hit_a     = in_window(in_sample_ff, level_a_ff, tolerance_ff);
   assign hit_c     = in_window(in_sample_ff, level_c_ff, tolerance_ff);
   assign hit_b     = in_window(in_sample_ff, level_b_ff, tolerance_ff);
   assign hit_d     = in_window(in_sample_ff, level_d_ff, tolerance_ff);
   assign hit_press = (in_sample_ff >= press_low_ff) && (in_sample_ff <= press_high_ff);

   // first match in the order a, c, b, d, then press
   always_comb begin
      event_in   = EV_NONE;
      site_in    = site_cur;
      site_write = 1'b0;
      if (in_range) begin
         if (hit_a) begin
            site_in    = SITE_A;
            site_write = 1'b1;
         end else if (hit_c) begin
            site_in    = SITE_C;
            site_write = 1'b1;
         end else if (hit_b) begin
            if (site_cur == SITE_A) begin
               event_in = EV_RIGHT;
            end else if (site_cur == SITE_C) begin
               event_in = EV_LEFT;
            end
            site_in    = SITE_EMPTY;
            site_write = 1'b1;
         end else if (hit_d) begin
            if (site_cur == SITE_C) begin
               event_in = EV_RIGHT;
            end else if (site_cur == SITE_A) begin
               event_in = EV_LEFT;
            end
            site_in    = SITE_EMPTY;
            site_write = 1'b1;
         end else if (hit_press) begin
            event_in = EV_PRESS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_a_ff    <= LEVEL_A_RESET;
         level_b_ff    <= LEVEL_B_RESET;
         level_c_ff    <= LEVEL_C_RESET;
         level_d_ff    <= LEVEL_D_RESET;
         tolerance_ff  <= TOLERANCE_RESET;
         press_low_ff  <= PRESS_LOW_RESET;
         press_high_ff <= PRESS_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LEVEL_A:    level_a_ff    <= csr_data;
            REG_LEVEL_B:    level_b_ff    <= csr_data;
            REG_LEVEL_C:    level_c_ff    <= csr_data;
            REG_LEVEL_D:    level_d_ff    <= csr_data;
            REG_TOLERANCE:  tolerance_ff  <= csr_data[TOL_BITS-1:0];
            REG_PRESS_LOW:  press_low_ff  <= csr_data;
            REG_PRESS_HIGH: press_high_ff <= csr_data;
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_channel_ff <= req_tdata[CHAN_BITS-1:0];
         in_sample_ff  <= req_tdata[CHAN_BITS +: SAMPLE_BITS];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_event_ff   <= event_in;
         rsp_channel_ff <= in_channel_ff;
      end
   end

   // site update when the item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            site_ff[i] <= SITE_EMPTY;
         end
      end else if (advance && in_valid_ff && site_write) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (int'(in_channel_ff) == i) begin
               site_ff[i] <= site_in;
            end
         end
      end
   end

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

   // an ignored channel never reports an event
   a_range_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && int'(rsp_channel_ff) >= CHANNELS) |-> (rsp_event_ff == EV_NONE))
      else $error("event on out of range channel");

   // a held item stays in the input register while the result is stalled
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_sample_ff)))
      else $error("input item lost during stall");

   // a direction event always clears the channel site
   a_dir_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_valid_ff && (event_in == EV_RIGHT || event_in == EV_LEFT))
      |-> (site_write && site_in == SITE_EMPTY))
      else $error("direction event without site clear");

endmodule

`default_nettype wire

### tb/adc_ladder_rotary_decoder_core_tb.sv
// self-checking stream testbench for the ladder rotary decoder core
module adc_ladder_rotary_decoder_core_tb;
   import alrd_pkg::*;

   localparam int CLOCK_HALF     = 10;
   localparam int RESET_CYCLES   = 4;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 180;
   // input register plus result register, with some margin
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int TIMEOUT_CYCLES = 400000;
   // index past the end of the register file, writes to it must be dropped
   localparam logic [CSR_IDX_BITS-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [CHAN_BITS-1:0]   chan;
      logic [SAMPLE_BITS-1:0] sample;
   } sample_item_type;

   typedef struct packed {
      event_type            code;
      logic [CHAN_BITS-1:0] chan;
   } decoded_event_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // channel [1:0], sample [13:2], zero pad above
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // event_code [1:0], event_channel [3:2], zero pad above
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   // local copy of the register file, updated on each accepted write
   logic [SAMPLE_BITS-1:0] cfg_level_a;
   logic [SAMPLE_BITS-1:0] cfg_level_b;
   logic [SAMPLE_BITS-1:0] cfg_level_c;
   logic [SAMPLE_BITS-1:0] cfg_level_d;
   logic [TOL_BITS-1:0]    cfg_tol;
   logic [SAMPLE_BITS-1:0] cfg_press_low;
   logic [SAMPLE_BITS-1:0] cfg_press_high;

   // per channel first site, mirrors the block's state
   site_type chan_site [CHANNELS];

   sample_item_type   sample_queue [$];
   decoded_event_type pending_events [$];

   int mismatches       = 0;
   int samples_accepted = 0;
   int events_checked   = 0;
   int right_events     = 0;
   int left_events      = 0;
   int press_events     = 0;
   int settings_applied = 0;

   // driver and receiver pacing
   int                burst_left = 1;
   int                gap_left   = 0;
   int                stall_mode = 0;
   int                mode_left  = 0;
   int                beat       = 0;
   sample_item_type   next_item;
   decoded_event_type accepted_event;
   decoded_event_type oldest_event;

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   adc_ladder_rotary_decoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // inclusive window, lower edge clamped at zero, upper edge wide enough not to wrap
   function automatic bit level_hit(input logic [SAMPLE_BITS-1:0] s,
                                    input logic [SAMPLE_BITS-1:0] lvl);
      int lo;
      int hi;
      lo = int'(lvl) - int'(cfg_tol);
      hi = int'(lvl) + int'(cfg_tol);
      if (lo < 0) lo = 0;
      return (int'(s) >= lo) && (int'(s) <= hi);
   endfunction

   // event for one sample; updates the site of its channel
   function automatic event_type decode_sample(input logic [CHAN_BITS-1:0]   ch,
                                               input logic [SAMPLE_BITS-1:0] s);
      site_type  held;
      event_type ev;
      ev = EV_NONE;
      // out-of-range channels are echoed with no event and touch no state
      if (int'(ch) < CHANNELS) begin
         held = chan_site[ch];
         // fixed priority A, C, B, D, then press
         if (level_hit(s, cfg_level_a)) begin
            chan_site[ch] = SITE_A;
         end else if (level_hit(s, cfg_level_c)) begin
            chan_site[ch] = SITE_C;
         end else if (level_hit(s, cfg_level_b)) begin
            if (held == SITE_A) ev = EV_RIGHT;
            else if (held == SITE_C) ev = EV_LEFT;
            chan_site[ch] = SITE_EMPTY;
         end else if (level_hit(s, cfg_level_d)) begin
            if (held == SITE_C) ev = EV_RIGHT;
            else if (held == SITE_A) ev = EV_LEFT;
            chan_site[ch] = SITE_EMPTY;
         end else if (s >= cfg_press_low && s <= cfg_press_high) begin
            ev = EV_PRESS;
         end
      end
      return ev;
   endfunction

   function automatic void queue_sample(input int ch, input int s);
      sample_item_type item;
      item.chan   = CHAN_BITS'(ch);
      item.sample = SAMPLE_BITS'(s);
      sample_queue.push_back(item);
   endfunction

   // random sample inside the window of lvl, with extra weight on both edges
   function automatic int near_level(input logic [SAMPLE_BITS-1:0] lvl);
      int lo;
      int hi;
      int pick;
      lo = int'(lvl) - int'(cfg_tol);
      hi = int'(lvl) + int'(cfg_tol);
      if (lo < 0) lo = 0;
      if (hi > SAMPLE_MAX) hi = SAMPLE_MAX;
      pick = $urandom_range(0, 7);
      if (pick == 0) return lo;
      if (pick == 1) return hi;
      return $urandom_range(hi, lo);
   endfunction

   // one noise item: uniform, just outside a window edge, or in the press window;
   // returns the number of items queued
   function automatic int queue_noise();
      logic [SAMPLE_BITS-1:0] lvl;
      int                     ch;
      int                     s;
      ch = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
         0, 1: s = $urandom_range(0, SAMPLE_MAX);
         2: begin
            case ($urandom_range(0, 3))
               0: lvl = cfg_level_a;
               1: lvl = cfg_level_b;
               2: lvl = cfg_level_c;
               default: lvl = cfg_level_d;
            endcase
            if ($urandom_range(0, 1)) s = int'(lvl) + int'(cfg_tol) + 1;
            else s = int'(lvl) - int'(cfg_tol) - 1;
            if (s < 0) s = 0;
            if (s > SAMPLE_MAX) s = SAMPLE_MAX;
         end
         default: begin
            if (cfg_press_low <= cfg_press_high) begin
               s = $urandom_range(cfg_press_high, cfg_press_low);
            end else begin
               s = $urandom_range(0, SAMPLE_MAX);
            end
         end
      endcase
      queue_sample(ch, s);
      return 1;
   endfunction

   // mostly first-site/second-site pairs on one channel, some noise in between
   task automatic queue_random_items(input int count);
      int queued;
      int gaps;
      int ch;
      queued = 0;
      while (queued < count) begin
         if ($urandom_range(0, 9) < 7) begin
            ch = $urandom_range(0, CHANNELS - 1);
            queue_sample(ch, near_level($urandom_range(0, 1) ? cfg_level_a : cfg_level_c));
            gaps = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (gaps) queued += queue_noise();
            queue_sample(ch, near_level($urandom_range(0, 1) ? cfg_level_b : cfg_level_d));
            queued += 2;
         end else begin
            queued += queue_noise();
         end
      end
   endtask

   function automatic bit stream_busy();
      return (sample_queue.size() != 0) || req_tvalid || (pending_events.size() != 0);
   endfunction

   // checked between edges so the driver and receiver have settled
   task automatic wait_idle();
      while (stream_busy()) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0]  idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_LEVEL_A:    cfg_level_a    = value;
         REG_LEVEL_B:    cfg_level_b    = value;
         REG_LEVEL_C:    cfg_level_c    = value;
         REG_LEVEL_D:    cfg_level_d    = value;
         REG_TOLERANCE:  cfg_tol        = value[TOL_BITS-1:0];
         REG_PRESS_LOW:  cfg_press_low  = value;
         REG_PRESS_HIGH: cfg_press_high = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int a, input int b, input int c, input int d,
                                 input int tol_word, input int plo, input int phi);
      csr_write(REG_LEVEL_A, CSR_DATA_BITS'(a));
      csr_write(REG_LEVEL_B, CSR_DATA_BITS'(b));
      csr_write(REG_LEVEL_C, CSR_DATA_BITS'(c));
      csr_write(REG_LEVEL_D, CSR_DATA_BITS'(d));
      csr_write(REG_TOLERANCE, CSR_DATA_BITS'(tol_word));
      csr_write(REG_PRESS_LOW, CSR_DATA_BITS'(plo));
      csr_write(REG_PRESS_HIGH, CSR_DATA_BITS'(phi));
      settings_applied++;
   endtask

   // sender: bursts of random length with random gaps, prediction on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted_event.code = decode_sample(req_tdata[CHAN_BITS-1:0],
                                                req_tdata[CHAN_BITS +: SAMPLE_BITS]);
            accepted_event.chan = req_tdata[CHAN_BITS-1:0];
            pending_events.push_back(accepted_event);
            samples_accepted++;
         end
         // only move on once the current item is gone
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               next_item = sample_queue.pop_front();
               req_tdata  <= REQ_DATA_BITS'({next_item.sample, next_item.chan});
               req_tvalid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  // a quarter of the bursts follow on with no gap at all
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each item against the oldest expectation, stalls on its own pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               $error("unexpected result item, tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               oldest_event = pending_events.pop_front();
               if (rsp_tdata[EVENT_BITS-1:0] !== oldest_event.code) begin
                  $error("event_code: expected %0d, actual %0d",
                         oldest_event.code, rsp_tdata[EVENT_BITS-1:0]);
                  mismatches++;
               end
               if (rsp_tdata[EVENT_BITS +: CHAN_BITS] !== oldest_event.chan) begin
                  $error("event_channel: expected %0d, actual %0d",
                         oldest_event.chan, rsp_tdata[EVENT_BITS +: CHAN_BITS]);
                  mismatches++;
               end
               events_checked++;
               case (oldest_event.code)
                  EV_RIGHT: right_events++;
                  EV_LEFT:  left_events++;
                  EV_PRESS: press_events++;
                  default: ;
               endcase
            end
         end
         // switch to a new random stall behavior whenever the current mode runs out
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         beat++;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ((beat % 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   initial begin
      int p;
      int a;
      int b;
      int c;
      int d;
      int tol;
      int tol_word;
      int plo;
      int phi;
      int drain;

      cfg_level_a    = LEVEL_A_RESET;
      cfg_level_b    = LEVEL_B_RESET;
      cfg_level_c    = LEVEL_C_RESET;
      cfg_level_d    = LEVEL_D_RESET;
      cfg_tol        = TOLERANCE_RESET;
      cfg_press_low  = PRESS_LOW_RESET;
      cfg_press_high = PRESS_HIGH_RESET;
      foreach (chan_site[i]) chan_site[i] = SITE_EMPTY;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: A 1024, B 2048, C 3072, D 3900, tolerance 100, press 10..32
      queue_sample(0, 1024);   // A then B, right
      queue_sample(0, 2048);
      queue_sample(1, 2972);   // C at its lower edge, then D at its upper edge, right
      queue_sample(1, 4000);
      queue_sample(2, 3172);   // C at its upper edge, then B at its lower edge, left
      queue_sample(2, 1948);
      queue_sample(0, 924);    // A at its lower edge, then D at its lower edge, left
      queue_sample(0, 3800);
      queue_sample(1, 2148);   // B with no site stored
      queue_sample(2, 4000);   // D with no site stored
      queue_sample(0, 1125);   // just outside A on both sides
      queue_sample(0, 923);
      queue_sample(0, 10);     // press window edges and just outside them
      queue_sample(0, 32);
      queue_sample(0, 9);
      queue_sample(0, 33);
      queue_sample(1, 1124);   // site survives a press, a miss and a foreign channel
      queue_sample(1, 20);
      queue_sample(1, 1500);
      queue_sample(3, 2048);
      queue_sample(1, 2048);
      queue_sample(3, 1024);   // out-of-range channel is only echoed
      queue_sample(2, SAMPLE_MAX);
      queue_sample(0, 1024);   // a later C replaces the A site
      queue_sample(0, 3072);
      queue_sample(0, 3900);
      wait_idle();

      // write to a register index that does not exist, levels must stay as they are
      csr_write(REG_UNUSED, CSR_DATA_BITS'($urandom_range(0, SAMPLE_MAX)));
      queue_sample(0, 1024);
      queue_sample(0, 2048);
      wait_idle();

      // overlapping windows with zero tolerance: A beats C and press, B beats D
      apply_settings(2000, 2100, 2000, 2100, 0, 2000, 2100);
      queue_sample(0, 2000);
      queue_sample(0, 2050);
      queue_sample(0, 2100);
      queue_sample(1, 1999);
      queue_sample(1, 2101);
      queue_sample(2, 2100);
      wait_idle();

      // widest tolerance: lower edge clamped at zero, upper edge past full scale,
      // empty press window; tolerance written with its unused upper bits set
      apply_settings(50, SAMPLE_MAX, 3000, SAMPLE_MAX, 12'hFFF, SAMPLE_MAX, 0);
      queue_sample(0, 0);
      queue_sample(0, SAMPLE_MAX);
      queue_sample(1, 3500);
      queue_sample(1, SAMPLE_MAX);
      queue_sample(2, 1500);
      queue_sample(2, SAMPLE_MAX);
      wait_idle();

      // random phases, one register setting each, extremes on selected phases
      for (p = 0; p < RANDOM_PHASES; p++) begin
         tol = $urandom_range(0, 300);
         a   = $urandom_range(0, 1023);
         b   = $urandom_range(1024, 2047);
         c   = $urandom_range(2048, 3071);
         d   = $urandom_range(3072, SAMPLE_MAX);
         plo = $urandom_range(0, SAMPLE_MAX);
         phi = plo + $urandom_range(0, 200);
         if (phi > SAMPLE_MAX) phi = SAMPLE_MAX;
         case (p)
            1: tol = 0;
            2: tol = (1 << TOL_BITS) - 1;
            3: begin
               a = 0;
               d = SAMPLE_MAX;
            end
            4: begin
               plo = 0;
               phi = SAMPLE_MAX;
            end
            5: begin
               plo = $urandom_range(2048, SAMPLE_MAX);
               phi = $urandom_range(0, 2047);
            end
            6: begin
               a   = $urandom_range(0, SAMPLE_MAX);
               b   = $urandom_range(0, SAMPLE_MAX);
               c   = $urandom_range(0, SAMPLE_MAX);
               d   = $urandom_range(0, SAMPLE_MAX);
               tol = $urandom_range(0, (1 << TOL_BITS) - 1);
            end
            7: begin
               b = SAMPLE_MAX;
               c = 0;
            end
            default: ;
         endcase
         // random upper bits above the tolerance field
         tol_word = ($urandom_range(0, 3) << TOL_BITS) | tol;
         apply_settings(a, b, c, d, tol_word, plo, phi);
         queue_random_items(PHASE_ITEMS);
         wait_idle();
      end

      // bounded drain, then anything left over is a failure
      drain = 0;
      while (stream_busy() && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (stream_busy()) begin
         $error("%0d expected result items never arrived", pending_events.size());
         mismatches++;
      end

      $display("covered %0d samples over %0d register settings, %0d results checked",
               samples_accepted, settings_applied + 1, events_checked);
      $display("events seen: %0d right, %0d left, %0d press",
               right_events, left_events, press_events);
      if (mismatches == 0) begin
         $display("adc_ladder_rotary_decoder_core_tb OK");
      end else begin
         $display("adc_ladder_rotary_decoder_core_tb NOT OK");
      end
      $finish;
   end

   // hard stop in case a handshake never completes
   initial begin
      #(TIMEOUT_CYCLES * 2 * CLOCK_HALF);
      $display("timeout with %0d results outstanding", pending_events.size());
      $display("adc_ladder_rotary_decoder_core_tb NOT OK");
      $finish;
   end

endmodule
